// ===== rtl/core/joystick_axis_deadband_curve_shaper_defines.svh =====
// Assertion macros for the joystick axis shaper.
`ifndef JOYSTICK_AXIS_DEADBAND_CURVE_SHAPER_DEFINES_SVH
`define JOYSTICK_AXIS_DEADBAND_CURVE_SHAPER_DEFINES_SVH
`ifndef SYNTHESIS
`define JADC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jadc: same-cycle check failed");
`define JADC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jadc: next-cycle check failed");
`else
`define JADC_ASSERT_IMP(label, ante, cons)
`define JADC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/jadc_pkg.sv =====
// Shared constants, types and fixed-point helpers for the joystick axis shaper.
`default_nettype none
package jadc_pkg;

  localparam int SAMPLE_BITS       = 12;
  localparam int CONFIG_FULL_SCALE = 32767;
  localparam int Q15_LIMIT         = 32767;
  localparam int Q15_BITS          = 15;
  localparam int ADDR_BITS         = 5;
  localparam int DATA_BITS         = 32;
  localparam int WEIGHT_BITS       = 16;

  typedef enum logic [2:0] {
    REG_MINIMUM  = 3'd0,
    REG_CENTER   = 3'd1,
    REG_MAXIMUM  = 3'd2,
    REG_DEADBAND = 3'd3,
    REG_INVERT   = 3'd4,
    REG_CURVE    = 3'd5,
    REG_SPEED    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic ok;
    logic zero;
    logic neg;
  } tag_t;

  // Floor divide by fs, where fs is 2**kk or 2**kk - 1 (fold the high part back in).
  function automatic logic [47:0] div_fold(input logic [47:0] x, input logic [16:0] fs,
                                           input logic [4:0] kk);
    logic [47:0] q;
    logic [47:0] r;
    logic [47:0] a;
    logic [47:0] c;
    logic [47:0] mask;
    c    = (48'd1 << kk) - {31'd0, fs};
    mask = (48'd1 << kk) - 48'd1;
    q    = '0;
    r    = x;
    for (int i = 0; i < 3; i++) begin
      a = r >> kk;
      q = q + a;
      r = (r & mask) + (c[0] ? a : 48'd0);
    end
    if (r >= {31'd0, fs}) begin
      q = q + 48'd1;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/joystick_axis_deadband_curve_shaper.sv =====
// Top level: config registers, deadband, divider, cubic blend and speed scaling.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_ready    | sample
//  output   | out_valid / out_ready  | valid_res, normalized, shaped, neutral
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// One request per cycle while the output is not held; out_valid rises after the
// request passes 27 register stages (sample, deadband, 16 divider stages, eight
// curve and speed stages, output register). The restoring divider sets the depth.
// All stages advance together; when the output is held, the whole pipe holds.
// Synchronous reset clears valid bits and restores register defaults.
`default_nettype none
`include "joystick_axis_deadband_curve_shaper_defines.svh"
module joystick_axis_deadband_curve_shaper #(
  parameter int SAMPLE_BITS = jadc_pkg::SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [SAMPLE_BITS-1:0]         sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                valid_res,
  output logic signed [15:0]                  normalized,
  output logic signed [15:0]                  shaped,
  output logic                                neutral,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [jadc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [jadc_pkg::DATA_BITS-1:0] pwdata,
  output logic [jadc_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int QB = jadc_pkg::Q15_BITS;
  localparam int WB = jadc_pkg::WEIGHT_BITS;
  localparam int FS = jadc_pkg::CONFIG_FULL_SCALE;
  localparam int FS_SHIFT = $clog2(FS);
  localparam int Q_SHIFT  = $clog2(jadc_pkg::Q15_LIMIT);

  // Configuration registers
  logic [SB-1:0] cal_min;
  logic [SB-1:0] cal_mid;
  logic [SB-1:0] cal_max;
  logic [SB-1:0] cal_dead;
  logic          invert_axis;
  logic [WB-1:0] curve_weight;
  logic [WB-1:0] speed_limit;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_min      <= '0;
      cal_mid      <= SB'(2048);
      cal_max      <= SB'(4095);
      cal_dead     <= SB'(64);
      invert_axis  <= 1'b0;
      curve_weight <= '0;
      speed_limit  <= WB'(32767);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        jadc_pkg::REG_MINIMUM:  cal_min      <= pwdata[SB-1:0];
        jadc_pkg::REG_CENTER:   cal_mid      <= pwdata[SB-1:0];
        jadc_pkg::REG_MAXIMUM:  cal_max      <= pwdata[SB-1:0];
        jadc_pkg::REG_DEADBAND: cal_dead     <= pwdata[SB-1:0];
        jadc_pkg::REG_INVERT:   invert_axis  <= pwdata[0];
        jadc_pkg::REG_CURVE:    curve_weight <= pwdata[WB-1:0];
        jadc_pkg::REG_SPEED:    speed_limit  <= pwdata[WB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      jadc_pkg::REG_MINIMUM:  prdata = 32'(cal_min);
      jadc_pkg::REG_CENTER:   prdata = 32'(cal_mid);
      jadc_pkg::REG_MAXIMUM:  prdata = 32'(cal_max);
      jadc_pkg::REG_DEADBAND: prdata = 32'(cal_dead);
      jadc_pkg::REG_INVERT:   prdata = 32'(invert_axis);
      jadc_pkg::REG_CURVE:    prdata = 32'(curve_weight);
      jadc_pkg::REG_SPEED:    prdata = 32'(speed_limit);
      default:                prdata = '0;
    endcase
  end

  // Derived calibration values, refreshed every cycle
  logic          cal_ok;
  logic [SB-1:0] lower;
  logic [SB-1:0] upper;
  logic [SB-1:0] span_lo;
  logic [SB-1:0] span_hi;
  logic [WB-1:0] wcl;
  logic [WB-1:0] fmw;
  logic [WB-1:0] lcl;

  always_ff @(posedge clk) begin
    cal_ok  <= (cal_min < cal_mid) && (cal_mid < cal_max) &&
               (cal_dead != '0) &&
               (cal_dead < SB'(cal_mid - cal_min)) &&
               (cal_dead < SB'(cal_max - cal_mid));
    lower   <= cal_mid - cal_dead;
    upper   <= cal_mid + cal_dead;
    span_lo <= SB'(cal_mid - cal_dead - cal_min);
    span_hi <= SB'(cal_max - cal_mid - cal_dead);
    wcl     <= (curve_weight > WB'(FS)) ? WB'(FS) : curve_weight;
    fmw     <= WB'(FS) - ((curve_weight > WB'(FS)) ? WB'(FS) : curve_weight);
    lcl     <= (speed_limit > WB'(FS)) ? WB'(FS) : speed_limit;
  end

  logic adv;
  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  // Stage a: capture sample
  logic          vld_a;
  logic [SB-1:0] s_a;
  // Stage b: distance past deadband edge
  logic           vld_b;
  logic [SB-1:0]  d_b;
  logic [SB-1:0]  span_b;
  jadc_pkg::tag_t tag_b;

  logic below;
  logic above;
  logic [SB-1:0] clo;
  logic [SB-1:0] chi;
  always_comb begin
    below = s_a < lower;
    above = s_a > upper;
    clo   = (s_a < cal_min) ? cal_min : s_a;
    chi   = (s_a > cal_max) ? cal_max : s_a;
  end

  logic [SB+QB-1:0] num_b;
  assign num_b = {d_b, {QB{1'b0}}} - (SB+QB)'(d_b);

  logic           vld_d;
  logic [QB-1:0]  q_d;
  jadc_pkg::tag_t tag_d;

  jadc_div #(.DEN_BITS(SB), .QUO_BITS(QB)) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (vld_b),
    .num     (num_b),
    .den     (span_b),
    .in_tag  (tag_b),
    .out_vld (vld_d),
    .quo     (q_d),
    .out_tag (tag_d)
  );

  logic [QB-1:0] m_d;
  assign m_d = tag_d.zero ? '0 : q_d;

  // Curve and speed stages
  logic vld_c1, vld_c2, vld_c3, vld_c4, vld_c5, vld_c6, vld_c7, vld_c8;
  jadc_pkg::tag_t tag_c1, tag_c2, tag_c3, tag_c4, tag_c5, tag_c6, tag_c7, tag_c8;
  logic [QB-1:0] m_c1, m_c2, m_c3, m_c4, m_c5, m_c6, m_c7, m_c8;
  logic [2*QB-1:0] sq_c1;
  logic [3*QB-1:0] cu_c2;
  logic [2*QB-1:0] t_c3;
  logic [QB-1:0]   cube_c4;
  logic [QB-1:0]   cube_c5;
  logic [WB+QB-1:0] p1_c5;
  logic [WB+QB:0]   sum_c6;
  logic [QB-1:0]    blend_c7;
  logic [WB+QB-1:0] prod_c8;

  logic [47:0] t_div;
  logic [47:0] cube_div;
  logic [47:0] blend_div;
  logic [47:0] mag_div;
  always_comb begin
    t_div     = jadc_pkg::div_fold(48'(cu_c2), 17'(jadc_pkg::Q15_LIMIT), 5'(Q_SHIFT));
    cube_div  = jadc_pkg::div_fold(48'(t_c3), 17'(jadc_pkg::Q15_LIMIT), 5'(Q_SHIFT));
    blend_div = jadc_pkg::div_fold(48'(sum_c6), 17'(FS), 5'(FS_SHIFT));
    mag_div   = jadc_pkg::div_fold(48'(prod_c8), 17'(FS), 5'(FS_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a  <= 1'b0;
      vld_b  <= 1'b0;
      vld_c1 <= 1'b0;
      vld_c2 <= 1'b0;
      vld_c3 <= 1'b0;
      vld_c4 <= 1'b0;
      vld_c5 <= 1'b0;
      vld_c6 <= 1'b0;
      vld_c7 <= 1'b0;
      vld_c8 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_a  <= in_valid;
      vld_b  <= vld_a;
      vld_c1 <= vld_d;
      vld_c2 <= vld_c1;
      vld_c3 <= vld_c2;
      vld_c4 <= vld_c3;
      vld_c5 <= vld_c4;
      vld_c6 <= vld_c5;
      vld_c7 <= vld_c6;
      vld_c8 <= vld_c7;
      out_valid <= vld_c8;
    end
  end

  logic [QB-1:0] mag_o;
  assign mag_o = mag_div[QB-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s_a <= sample;

      d_b       <= below ? SB'(lower - clo) : (above ? SB'(chi - upper) : '0);
      span_b    <= below ? span_lo : span_hi;
      tag_b.ok   <= cal_ok;
      tag_b.zero <= ~below & ~above;
      tag_b.neg  <= below ^ invert_axis;

      m_c1   <= m_d;
      tag_c1 <= tag_d;
      sq_c1  <= m_d * m_d;

      m_c2   <= m_c1;
      tag_c2 <= tag_c1;
      cu_c2  <= sq_c1 * m_c1;

      m_c3   <= m_c2;
      tag_c3 <= tag_c2;
      t_c3   <= t_div[2*QB-1:0];

      m_c4    <= m_c3;
      tag_c4  <= tag_c3;
      cube_c4 <= cube_div[QB-1:0];

      m_c5    <= m_c4;
      tag_c5  <= tag_c4;
      cube_c5 <= cube_c4;
      p1_c5   <= fmw * m_c4;

      m_c6   <= m_c5;
      tag_c6 <= tag_c5;
      sum_c6 <= (WB+QB+1)'(p1_c5) + (WB+QB+1)'(wcl * cube_c5);

      m_c7     <= m_c6;
      tag_c7   <= tag_c6;
      blend_c7 <= blend_div[QB-1:0];

      m_c8    <= m_c7;
      tag_c8  <= tag_c7;
      prod_c8 <= blend_c7 * lcl;

      valid_res  <= tag_c8.ok;
      neutral    <= ~tag_c8.ok | (m_c8 == '0);
      normalized <= ~tag_c8.ok ? 16'sd0 :
                    (tag_c8.neg ? -$signed({1'b0, m_c8}) : $signed({1'b0, m_c8}));
      shaped     <= ~tag_c8.ok ? 16'sd0 :
                    (tag_c8.neg ? -$signed({1'b0, mag_o}) : $signed({1'b0, mag_o}));
    end
  end

  `JADC_ASSERT_IMP(a_bad_cal_zero, out_valid && !valid_res, normalized == 16'sd0 && shaped == 16'sd0 && neutral)
  `JADC_ASSERT_IMP(a_neutral_match, out_valid && valid_res, neutral == (normalized == 16'sd0))
  `JADC_ASSERT_IMP(a_zero_shaped, out_valid && normalized == 16'sd0, shaped == 16'sd0)
  `JADC_ASSERT_IMP(a_hold_input, out_valid && !out_ready, !in_ready)

endmodule
`default_nettype wire

// ===== rtl/core/jadc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried along.
`default_nettype none
module jadc_div #(
  parameter int DEN_BITS = jadc_pkg::SAMPLE_BITS,
  parameter int QUO_BITS = jadc_pkg::Q15_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_vld,
  input  wire logic [DEN_BITS+QUO_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0]          den,
  input  wire jadc_pkg::tag_t               in_tag,
  output logic                              out_vld,
  output logic [QUO_BITS-1:0]               quo,
  output jadc_pkg::tag_t                    out_tag
);

  localparam int NST = QUO_BITS + 1;

  logic                vld   [NST];
  logic [DEN_BITS-1:0] rem   [NST];
  logic [QUO_BITS-1:0] nlo   [NST];
  logic [QUO_BITS-1:0] qacc  [NST];
  logic [DEN_BITS-1:0] dsor  [NST];
  jadc_pkg::tag_t      tag   [NST];

  logic [DEN_BITS:0]   trial [QUO_BITS];
  logic [DEN_BITS:0]   diff  [QUO_BITS];
  logic                ge    [QUO_BITS];
  logic [DEN_BITS-1:0] rem_next [QUO_BITS];

  always_comb begin
    for (int i = 0; i < QUO_BITS; i++) begin
      trial[i]    = {rem[i], nlo[i][QUO_BITS-1]};
      diff[i]     = trial[i] - {1'b0, dsor[i]};
      ge[i]       = trial[i] >= {1'b0, dsor[i]};
      rem_next[i] = ge[i] ? diff[i][DEN_BITS-1:0] : trial[i][DEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_vld;
      for (int i = 0; i < QUO_BITS; i++) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= num[DEN_BITS+QUO_BITS-1:QUO_BITS];
      nlo[0]  <= num[QUO_BITS-1:0];
      qacc[0] <= '0;
      dsor[0] <= den;
      tag[0]  <= in_tag;
      for (int i = 0; i < QUO_BITS; i++) begin
        rem[i+1]  <= rem_next[i];
        nlo[i+1]  <= nlo[i] << 1;
        qacc[i+1] <= {qacc[i][QUO_BITS-2:0], ge[i]};
        dsor[i+1] <= dsor[i];
        tag[i+1]  <= tag[i];
      end
    end
  end

  assign out_vld = vld[QUO_BITS];
  assign quo     = qacc[QUO_BITS];
  assign out_tag = tag[QUO_BITS];

endmodule
`default_nettype wire

// ===== dv/joystick_axis_deadband_curve_shaper_tb.sv =====
// Self-checking testbench for the joystick axis deadband and curve shaper.
`timescale 1ns / 100ps
`default_nettype none

module joystick_axis_deadband_curve_shaper_tb;

  localparam int LATENCY = 26;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             ok;
    logic signed [15:0] norm;
    logic signed [15:0] shp;
    logic             neut;
  } axis_result_t;

  // Scoreboard: calibration copy, axis predictor and pending results.
  class axis_scoreboard;
    logic [11:0] min_c, ctr_c, max_c, dead_c;
    logic        inv;
    logic [15:0] curve_w, speed_w;
    axis_result_t pending[$];
    int errors;
    int checked;

    function new();
      min_c = 12'd0; ctr_c = 12'd2048; max_c = 12'd4095; dead_c = 12'd64;
      inv = 1'b0; curve_w = 16'd0; speed_w = 16'd32767;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(jadc_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        jadc_pkg::REG_MINIMUM:  min_c = v[11:0];
        jadc_pkg::REG_CENTER:   ctr_c = v[11:0];
        jadc_pkg::REG_MAXIMUM:  max_c = v[11:0];
        jadc_pkg::REG_DEADBAND: dead_c = v[11:0];
        jadc_pkg::REG_INVERT:   inv = v[0];
        jadc_pkg::REG_CURVE:    curve_w = v[15:0];
        jadc_pkg::REG_SPEED:    speed_w = v[15:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
    endfunction

    function axis_result_t shape_sample(logic [11:0] s);
      axis_result_t r;
      longint lo, hi, c, n, w, m, cube, blend, lim, q, x;
      r = '0;
      if (!(min_c < ctr_c && ctr_c < max_c && dead_c != 0 &&
            dead_c < ctr_c - min_c && dead_c < max_c - ctr_c)) begin
        r.neut = 1'b1;
        return r;
      end
      lo = ctr_c - dead_c;
      hi = ctr_c + dead_c;
      if (s >= lo && s <= hi) n = 0;
      else if (s < lo) begin
        c = (s < min_c) ? min_c : s;
        n = -(((lo - c) * 32767) / (lo - min_c));
      end else begin
        c = (s > max_c) ? max_c : s;
        n = ((c - hi) * 32767) / (max_c - hi);
      end
      if (inv) n = -n;
      n = sat(n);
      w = (curve_w > 32767) ? 32767 : curve_w;
      m = (n < 0) ? -n : n;
      cube = (m * m * m) / (longint'(32767) * 32767);
      blend = ((32767 - w) * m + w * cube) / 32767;
      x = sat((n < 0) ? -blend : blend);
      lim = (speed_w > 32767) ? 32767 : speed_w;
      m = (x < 0) ? -x : x;
      q = (m * lim) / 32767;
      r.ok = 1'b1;
      r.norm = 16'(n);
      r.shp = 16'(sat((x < 0) ? -q : q));
      r.neut = (n == 0);
      return r;
    endfunction

    function void note_request(logic [11:0] s);
      pending.push_back(shape_sample(s));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(axis_result_t got);
      axis_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending", 1, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.ok !== want.ok) report("valid_res", got.ok, want.ok);
      if (got.norm !== want.norm) report("normalized", got.norm, want.norm);
      if (got.shp !== want.shp) report("shaped", got.shp, want.shp);
      if (got.neut !== want.neut) report("neutral", got.neut, want.neut);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [jadc_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_res, neutral;
  logic signed [15:0] normalized, shaped;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [jadc_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [jadc_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [jadc_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  int dir_reset [11] = '{0, 4095, 2048, 1984, 1983, 2112, 2113, 1, 4094, 12'hAAA, 12'h555};
  int dir_curve [9]  = '{0, 255, 256, 1000, 1990, 2010, 2011, 3000, 4095};
  int dir_tight [6]  = '{0, 1, 2, 3, 4, 4095};

  axis_scoreboard sb = new();
  int cycles = 0;
  bit calm = 1'b0;      // no idling on either side
  bit hold_off = 1'b0;  // long receiver stall

  always #10 clk = ~clk;

  joystick_axis_deadband_curve_shaper dut (
    .clk, .rst, .in_valid, .in_ready, .sample, .out_valid, .out_ready,
    .valid_res, .normalized, .shaped, .neutral,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("joystick_axis_deadband_curve_shaper_tb: FAIL");
      $finish;
    end
  end

  // Receiver: check accepted results, stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result('{valid_res, normalized, shaped, neutral});
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 9);
    end
  end

  task automatic write_reg(jadc_pkg::reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= jadc_pkg::ADDR_BITS'(4 * int'(idx)); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_sample(logic [11:0] s);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_request(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_calibration(int mn, int ct, int mx, int db, int iv, int cw, int sp);
    write_reg(jadc_pkg::REG_MINIMUM, mn);
    write_reg(jadc_pkg::REG_CENTER, ct);
    write_reg(jadc_pkg::REG_MAXIMUM, mx);
    write_reg(jadc_pkg::REG_DEADBAND, db);
    write_reg(jadc_pkg::REG_INVERT, iv);
    write_reg(jadc_pkg::REG_CURVE, cw);
    write_reg(jadc_pkg::REG_SPEED, sp);
  endtask

  // Some samples near the calibrated points, most anywhere.
  function automatic logic [11:0] pick_sample();
    int k;
    int base;
    k = $urandom_range(9);
    case (k)
      0, 1: return 12'($urandom);
      2: base = sb.min_c;
      3: base = sb.max_c;
      4: base = sb.ctr_c - sb.dead_c;
      5: base = sb.ctr_c + sb.dead_c;
      default: return 12'($urandom_range(4095));
    endcase
    return 12'(base + $urandom_range(8) - 4);
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_sample(pick_sample());
  endtask

  initial begin
    int mn, ct, mx, db;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset calibration, field extremes and deadband edges.
    foreach (dir_reset[i]) send_sample(12'(dir_reset[i]));
    drain();
    // Full curve, inverted, oversized weights and upper register bits set.
    set_calibration(32'hFFFF_F100, 2000, 3000, 10, 32'hFFFF_FFFF, 65535, 65535);
    foreach (dir_curve[i]) send_sample(12'(dir_curve[i]));
    drain();
    // Invalid calibrations: zero deadband, deadband too wide, misordered ends.
    set_calibration(0, 2048, 4095, 0, 0, 16384, 0);
    send_sample(12'd100);
    drain();
    write_reg(jadc_pkg::REG_DEADBAND, 2048);
    send_sample(12'd4000);
    drain();
    write_reg(jadc_pkg::REG_DEADBAND, 5);
    write_reg(jadc_pkg::REG_MINIMUM, 3000);
    send_sample(12'd0);
    drain();
    // Tightest valid span.
    set_calibration(0, 2, 4, 1, 0, 32767, 32767);
    foreach (dir_tight[i]) send_sample(12'(dir_tight[i]));
    drain();

    // Random phases with fresh calibrations, mostly valid.
    for (int ph = 0; ph < 14; ph++) begin
      mn = $urandom_range(1500);
      mx = $urandom_range(4095, 2600);
      ct = $urandom_range(mx - 2, mn + 2);
      db = $urandom_range((ct - mn < mx - ct ? ct - mn : mx - ct) - 1, 1);
      if (ph % 5 == 4) db = $urandom_range(4095);
      set_calibration(mn, ct, mx, db, $urandom_range(1),
                      ph == 0 ? 0 : $urandom_range(65535),
                      ph == 1 ? 0 : $urandom_range(65535));
      calm = (ph == 3);
      if (ph == 6) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (200) @(posedge clk);
            hold_off <= 1'b0;
          end
          random_phase(50);
        join
      end else begin
        random_phase(50);
      end
      calm = 1'b0;
      drain();
    end

    $display("covered %0d checked results over directed, invalid and 14 random calibrations",
             sb.checked);
    if (sb.errors == 0)
      $display("joystick_axis_deadband_curve_shaper_tb: PASS");
    else
      $display("joystick_axis_deadband_curve_shaper_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
